/* design/uvs_pkg.sv */
package uvs_pkg;

  localparam int SEG_W        = 11;
  localparam int MAX_SEGMENTS = 1024;
  localparam int POS_FRAC     = 14;
  localparam int Q60_SHIFT    = 60 - POS_FRAC;
  localparam int POS_W        = 16;
  localparam int TEX_W        = 17;
  localparam int IDX_W        = 21;
  localparam int DIV_STEPS    = 33;
  localparam int QW           = DIV_STEPS + 1;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = 5;
  localparam int CW           = 34;
  localparam int AW           = 3;
  localparam int DW           = 32;

  // stage positions in the pipeline
  localparam int STG_A   = DIV_STEPS;
  localparam int STG_B   = STG_A + CORDIC_STEPS + 1;
  localparam int STG_C   = STG_B + 1;
  localparam int STG_D   = STG_C + 1;
  localparam int LATENCY = STG_D + 1;

  localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(32'h26DD3B6A);
  localparam logic signed [CW-1:0] Q30_ONE     = CW'(33'sh040000000);

  localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
    30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4, 30'h028B0D43, 30'h0145D7E1,
    30'h00A2F61E, 30'h00517C55, 30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
    30'h00028BE6, 30'h000145F3, 30'h0000A2FA, 30'h0000517D, 30'h000028BE, 30'h0000145F,
    30'h00000A30, 30'h00000518, 30'h0000028C, 30'h00000146, 30'h000000A3, 30'h00000051
  };

  typedef enum logic {
    REG_X_SEGMENTS = 1'b0,
    REG_Y_SEGMENTS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [SEG_W-1:0] rem;
    logic [QW-1:0]    quo;
  } div_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cor_t;

  typedef struct packed {
    logic [1:0]         quad;
    logic signed [31:0] res;
  } phase_t;

  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
  } sc_t;

  typedef struct packed {
    logic [SEG_W-1:0] column;
    logic [SEG_W-1:0] row;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    logic [1:0]       quad_h;
    logic [1:0]       quad_v;
    logic             zero_h;
    logic             zero_v;
  } side_t;

  function automatic logic [SEG_W-1:0] clamp_seg(input logic [SEG_W-1:0] s);
    if (s == '0) return SEG_W'(1);
    if (s > SEG_W'(MAX_SEGMENTS)) return SEG_W'(MAX_SEGMENTS);
    return s;
  endfunction

  // n == d gives an exact power of two; otherwise plain long division
  function automatic div_t div_init(input logic [SEG_W-1:0] n, input logic [SEG_W-1:0] d);
    div_t r;
    if (n == d) begin
      r.rem = '0;
      r.quo = QW'(1);
    end else begin
      r.rem = n;
      r.quo = '0;
    end
    return r;
  endfunction

  function automatic phase_t phase_split(input logic [31:0] ph);
    phase_t p;
    logic [31:0] sum;
    sum    = ph + 32'h20000000;
    p.quad = sum[31:30];
    p.res  = $signed(ph - {sum[31:30], 30'b0});
    return p;
  endfunction

  function automatic sc_t rot_quad(input logic [1:0] quad, input logic zero,
                                   input logic signed [CW-1:0] x,
                                   input logic signed [CW-1:0] y);
    sc_t r;
    logic signed [CW-1:0] xa;
    logic signed [CW-1:0] ya;
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] s;
    xa = zero ? Q30_ONE : x;
    ya = zero ? '0 : y;
    case (quad)
      2'd0:    begin c = xa;  s = ya;  end
      2'd1:    begin c = -ya; s = xa;  end
      2'd2:    begin c = -xa; s = -ya; end
      default: begin c = ya;  s = -xa; end
    endcase
    r.c = c[31:0];
    r.s = s[31:0];
    return r;
  endfunction

  function automatic logic [POS_W-1:0] round_q60(input logic signed [63:0] v);
    logic signed [63:0] t;
    logic signed [63:0] lim;
    t   = (v + (64'sd1 <<< (Q60_SHIFT - 1))) >>> Q60_SHIFT;
    lim = 64'sd1 <<< POS_FRAC;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    return t[POS_W-1:0];
  endfunction

endpackage

/* design/uvs_if.sv */
interface uvs_req_if;
  logic        valid;
  logic        ready;
  logic [10:0] column;
  logic [10:0] row;

  modport source (output valid, column, row, input ready);
  modport sink   (input valid, column, row, output ready);
endinterface

interface uvs_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;
  logic [20:0]        idx_top_left;
  logic [20:0]        idx_top_right;
  logic [20:0]        idx_bottom_left;
  logic [20:0]        idx_bottom_right;
  logic               quad_valid;
  logic               out_of_range;

  modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, idx_top_left,
                  idx_top_right, idx_bottom_left, idx_bottom_right, quad_valid,
                  out_of_range, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, idx_top_left,
                  idx_top_right, idx_bottom_left, idx_bottom_right, quad_valid,
                  out_of_range, output ready);
endinterface

/* design/uvs_div_cell.sv */
module uvs_div_cell (
  input  logic                   clk,
  input  logic                   en,
  input  logic [uvs_pkg::SEG_W-1:0] divisor,
  input  uvs_pkg::div_t          din,
  output uvs_pkg::div_t          dout
);
  import uvs_pkg::*;

  logic [SEG_W:0]   rem2;
  logic             ge;
  div_t             dout_next;

  // one restoring step: shift in a zero, subtract when it fits
  always_comb begin
    rem2 = {din.rem, 1'b0};
    ge   = rem2 >= {1'b0, divisor};
    dout_next.rem = ge ? SEG_W'(rem2 - {1'b0, divisor}) : rem2[SEG_W-1:0];
    dout_next.quo = {din.quo[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

/* design/uvs_cordic_cell.sv */
module uvs_cordic_cell (
  input  logic                       clk,
  input  logic                       en,
  input  logic [uvs_pkg::STEP_W-1:0] step,
  input  uvs_pkg::cor_t              din,
  output uvs_pkg::cor_t              dout
);
  import uvs_pkg::*;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] ang;
  cor_t                 dout_next;

  always_comb begin
    dx  = $signed(din.y) >>> step;
    dy  = $signed(din.x) >>> step;
    ang = $signed({{(CW-30){1'b0}}, ATAN_TURNS[step]});
    if (!din.z[CW-1]) begin
      dout_next.x = din.x - dx;
      dout_next.y = din.y + dy;
      dout_next.z = din.z - ang;
    end else begin
      dout_next.x = din.x + dx;
      dout_next.y = din.y - dy;
      dout_next.z = din.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= dout_next;
    end
  end

endmodule

/* design/uv_sphere_vertex_generator.sv */
// channel | dir | handshake     | payload
// req     | in  | valid/ready   | column, row
// rsp     | out | valid/ready   | pos_x/y/z, tex_u/v, four quad indices, quad_valid,
//         |     |               | out_of_range
// apb     | in  | psel/penable  | x_segments @0x0, y_segments @0x4
//
// One grid point per cycle when not stalled. Stages: 33 long-division cells, one phase
// reduction stage, 24 CORDIC cells, then rotate, multiply and round stages.
// The final stage is the output register. When it holds an untaken result the
// whole chain freezes and req.ready drops. Synchronous reset clears the valid
// chain and sets the segment counts to 36 and 18.
module uv_sphere_vertex_generator (
  input  logic                      clk,
  input  logic                      rst,
  uvs_req_if.sink                   req,
  uvs_rsp_if.source                 rsp,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [uvs_pkg::AW-1:0]    paddr,
  input  logic [uvs_pkg::DW-1:0]    pwdata,
  output logic [uvs_pkg::DW-1:0]    prdata,
  output logic                      pready
);
  import uvs_pkg::*;

  logic [SEG_W-1:0] x_segments;
  logic [SEG_W-1:0] y_segments;
  logic [SEG_W-1:0] xs;
  logic [SEG_W-1:0] ys;
  logic             en;
  logic [LATENCY-1:0] vld;
  side_t            side [LATENCY];

  div_t             dq [3][DIV_STEPS];
  div_t             dinit [3];
  logic [SEG_W-1:0] dvs [3];
  cor_t             cq [2][CORDIC_STEPS];
  cor_t             cinit [2];

  // stage A
  logic signed [31:0] res_h;
  logic signed [31:0] res_v;
  side_t              side_a;
  phase_t             ph_h;
  phase_t             ph_v;
  logic [QW:0]        th;
  logic [QW-1:0]      tv;
  logic [18:0]        tu_r;
  logic [18:0]        tv_r;
  logic [QW-1:0]      qh;
  logic [QW-1:0]      qv;
  logic [QW-1:0]      qt;

  // stage B
  sc_t                sc_h;
  sc_t                sc_v;
  logic signed [31:0] ch;
  logic signed [31:0] sh;
  logic signed [31:0] cv;
  logic signed [31:0] sv;

  // stage C
  logic signed [63:0] prod_x;
  logic signed [63:0] prod_y;
  logic signed [63:0] prod_z;
  logic [IDX_W-1:0]   tl;
  logic [IDX_W-1:0]   bl;
  logic               qvalid;
  logic               oor;
  logic [SEG_W:0]     xp1;
  logic [2*SEG_W:0]   rowmul;
  logic [2*SEG_W:0]   tl_full;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      x_segments <= SEG_W'(36);
      y_segments <= SEG_W'(18);
    end else if (psel && penable && pwrite) begin
      case (reg_idx_t'(paddr[2]))
        REG_X_SEGMENTS: x_segments <= pwdata[SEG_W-1:0];
        REG_Y_SEGMENTS: y_segments <= pwdata[SEG_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_X_SEGMENTS: prdata = {{(DW-SEG_W){1'b0}}, x_segments};
      REG_Y_SEGMENTS: prdata = {{(DW-SEG_W){1'b0}}, y_segments};
      default:        prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign xs = clamp_seg(x_segments);
  assign ys = clamp_seg(y_segments);

  assign en        = !vld[LATENCY-1] || rsp.ready;
  assign req.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LATENCY-2:0], req.valid};
    end
  end

  // long division lanes: column/X, row/Y, (X-column)/X, each scaled by 2^33
  always_comb begin
    dvs[0]   = xs;
    dvs[1]   = ys;
    dvs[2]   = xs;
    dinit[0] = div_init(req.column, xs);
    dinit[1] = div_init(req.row, ys);
    dinit[2] = div_init(SEG_W'(xs - req.column), xs);
  end

  for (genvar l = 0; l < 3; l++) begin : g_div_lane
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div_step
      if (k == 0) begin : g_first
        uvs_div_cell u_cell (.clk(clk), .en(en), .divisor(dvs[l]), .din(dinit[l]),
                             .dout(dq[l][k]));
      end else begin : g_rest
        uvs_div_cell u_cell (.clk(clk), .en(en), .divisor(dvs[l]), .din(dq[l][k-1]),
                             .dout(dq[l][k]));
      end
    end
  end

  // stage A: rounding of quotients, quadrant split
  always_comb begin
    qh   = dq[0][DIV_STEPS-1].quo;
    qv   = dq[1][DIV_STEPS-1].quo;
    qt   = dq[2][DIV_STEPS-1].quo;
    th   = {1'b0, qh} + (QW+1)'(1);
    tv   = {1'b0, qv[QW-1:1]} + QW'(1);
    tu_r = {1'b0, qt[QW-1:16]} + 19'd1;
    tv_r = {1'b0, qv[QW-1:16]} + 19'd1;
    ph_h = phase_split(th[32:1]);
    ph_v = phase_split(tv[32:1]);
    side_a        = side[STG_A-1];
    side_a.tex_u  = tu_r[17:1];
    side_a.tex_v  = tv_r[17:1];
    side_a.quad_h = ph_h.quad;
    side_a.quad_v = ph_v.quad;
    side_a.zero_h = ph_h.res == '0;
    side_a.zero_v = ph_v.res == '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0].column <= req.column;
      side[0].row    <= req.row;
      side[0].tex_u  <= '0;
      side[0].tex_v  <= '0;
      side[0].quad_h <= '0;
      side[0].quad_v <= '0;
      side[0].zero_h <= 1'b0;
      side[0].zero_v <= 1'b0;
      for (int s = 1; s < LATENCY; s++) begin
        if (s == STG_A) begin
          side[s] <= side_a;
        end else begin
          side[s] <= side[s-1];
        end
      end
      res_h <= ph_h.res;
      res_v <= ph_v.res;
    end
  end

  always_comb begin
    cinit[0].x = CORDIC_GAIN;
    cinit[0].y = '0;
    cinit[0].z = CW'(res_h);
    cinit[1].x = CORDIC_GAIN;
    cinit[1].y = '0;
    cinit[1].z = CW'(res_v);
  end

  for (genvar l = 0; l < 2; l++) begin : g_cor_lane
    for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cor_step
      if (j == 0) begin : g_first
        uvs_cordic_cell u_cell (.clk(clk), .en(en), .step(STEP_W'(j)), .din(cinit[l]),
                                .dout(cq[l][j]));
      end else begin : g_rest
        uvs_cordic_cell u_cell (.clk(clk), .en(en), .step(STEP_W'(j)), .din(cq[l][j-1]),
                                .dout(cq[l][j]));
      end
    end
  end

  // stage B: quadrant rotation
  always_comb begin
    sc_h = rot_quad(side[STG_B-1].quad_h, side[STG_B-1].zero_h,
                    cq[0][CORDIC_STEPS-1].x, cq[0][CORDIC_STEPS-1].y);
    sc_v = rot_quad(side[STG_B-1].quad_v, side[STG_B-1].zero_v,
                    cq[1][CORDIC_STEPS-1].x, cq[1][CORDIC_STEPS-1].y);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ch <= sc_h.c;
      sh <= sc_h.s;
      cv <= sc_v.c;
      sv <= sc_v.s;
    end
  end

  // stage C: products and indices
  always_comb begin
    xp1     = {1'b0, xs} + (SEG_W+1)'(1);
    rowmul  = (2*SEG_W+1)'(side[STG_C-1].row * xp1);
    tl_full = rowmul + (2*SEG_W+1)'(side[STG_C-1].column);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= ch * sv;
      prod_z <= sh * sv;
      prod_y <= {{2{cv[31]}}, cv, 30'b0};
      tl     <= tl_full[IDX_W-1:0];
      bl     <= IDX_W'(tl_full[IDX_W-1:0] + IDX_W'(xp1));
      qvalid <= (side[STG_C-1].column < xs) && (side[STG_C-1].row < ys);
      oor    <= (side[STG_C-1].column > xs) || (side[STG_C-1].row > ys);
    end
  end

  // stage D: output register
  always_ff @(posedge clk) begin
    if (en) begin
      rsp.out_of_range <= oor;
      if (oor) begin
        rsp.pos_x            <= '0;
        rsp.pos_y            <= '0;
        rsp.pos_z            <= '0;
        rsp.tex_u            <= '0;
        rsp.tex_v            <= '0;
        rsp.idx_top_left     <= '0;
        rsp.idx_top_right    <= '0;
        rsp.idx_bottom_left  <= '0;
        rsp.idx_bottom_right <= '0;
        rsp.quad_valid       <= 1'b0;
      end else begin
        rsp.pos_x            <= round_q60(prod_x);
        rsp.pos_y            <= round_q60(prod_y);
        rsp.pos_z            <= round_q60(prod_z);
        rsp.tex_u            <= side[STG_D-1].tex_u;
        rsp.tex_v            <= side[STG_D-1].tex_v;
        rsp.idx_top_left     <= tl;
        rsp.idx_top_right    <= IDX_W'(tl + IDX_W'(1));
        rsp.idx_bottom_left  <= bl;
        rsp.idx_bottom_right <= IDX_W'(bl + IDX_W'(1));
        rsp.quad_valid       <= qvalid;
      end
    end
  end

  assign rsp.valid = vld[LATENCY-1];

endmodule

/* design/uvs_checker.sv */
module uvs_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [15:0] pos_x,
  input logic [16:0] tex_u,
  input logic [16:0] tex_v,
  input logic [20:0] idx_top_left,
  input logic [20:0] idx_top_right,
  input logic        quad_valid,
  input logic        out_of_range
);

  a_rst_clears: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("stalled result dropped");

  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && out_of_range |-> pos_x == 16'd0 && !quad_valid && idx_top_left == 21'd0)
    else $error("out of range result not cleared");

  a_right_idx: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !out_of_range |-> idx_top_right == 21'(idx_top_left + 21'd1))
    else $error("right index mismatch");

  a_quad_tex: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && quad_valid |-> !out_of_range && tex_v != 17'h10000 && tex_u != 17'd0)
    else $error("texture coordinate at edge for an interior quad");

endmodule

bind uv_sphere_vertex_generator uvs_checker u_uvs_checker (
  .clk(clk),
  .rst(rst),
  .rsp_valid(rsp.valid),
  .rsp_ready(rsp.ready),
  .pos_x(rsp.pos_x),
  .tex_u(rsp.tex_u),
  .tex_v(rsp.tex_v),
  .idx_top_left(rsp.idx_top_left),
  .idx_top_right(rsp.idx_top_right),
  .quad_valid(rsp.quad_valid),
  .out_of_range(rsp.out_of_range)
);

/* dv/uv_sphere_vertex_generator_tb.sv */
module uv_sphere_vertex_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import uvs_pkg::*;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic [20:0]        idx_tl;
    logic [20:0]        idx_tr;
    logic [20:0]        idx_bl;
    logic [20:0]        idx_br;
    logic               quad_valid;
    logic               out_of_range;
  } vertex_t;

  localparam int IDLE_LIMIT = 20000;

  localparam logic signed [63:0] ATAN_TBL [24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  class vertex_scoreboard;
    vertex_t pending[$];
    logic [10:0] xseg = 11'd36;
    logic [10:0] yseg = 11'd18;
    int errors = 0;
    int checked = 0;

    function logic [63:0] seg_limit(logic [10:0] s);
      if (s == 0) return 1;
      if (s > 1024) return 1024;
      return s;
    endfunction

    function void turn_sincos(logic [31:0] ph, output logic signed [63:0] c,
                              output logic signed [63:0] s);
      logic [31:0] sum;
      logic [1:0] q;
      logic signed [63:0] r, x, y, z, dx, dy;
      sum = ph + 32'h20000000;
      q = sum[31:30];
      r = 64'($signed(ph - {q, 30'b0}));
      if (r == 0) begin
        x = 64'sd1 <<< 30;
        y = 0;
      end else begin
        x = 64'sh26DD3B6A;
        y = 0;
        z = r;
        for (int i = 0; i < 24; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_TBL[i];
          end else begin
            x += dx; y -= dy; z += ATAN_TBL[i];
          end
        end
      end
      case (q)
        2'd0: begin c = x; s = y; end
        2'd1: begin c = -y; s = x; end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    function logic [15:0] q60_to_pos(logic signed [63:0] v);
      logic signed [63:0] t;
      t = (v + (64'sd1 <<< 45)) >>> 46;
      if (t > 16384) t = 16384;
      if (t < -16384) t = -16384;
      return t[15:0];
    endfunction

    function void note_point(logic [10:0] col_in, logic [10:0] row_in);
      vertex_t e;
      logic [63:0] nx, ny, col, row, tl, bl;
      logic [31:0] ph_h, ph_v;
      logic signed [63:0] ch, sh, cv, sv;
      nx = seg_limit(xseg);
      ny = seg_limit(yseg);
      col = col_in;
      row = row_in;
      e = '0;
      if (col > nx || row > ny) begin
        e.out_of_range = 1;
      end else begin
        ph_h = 32'(((col << 33) + nx) / (2 * nx));
        ph_v = 32'(((row << 32) + ny) / (2 * ny));
        turn_sincos(ph_h, ch, sh);
        turn_sincos(ph_v, cv, sv);
        e.pos_x = q60_to_pos(ch * sv);
        e.pos_y = q60_to_pos(cv * (64'sd1 <<< 30));
        e.pos_z = q60_to_pos(sh * sv);
        e.tex_u = 17'((((nx - col) << 17) + nx) / (2 * nx));
        e.tex_v = 17'(((row << 17) + ny) / (2 * ny));
        tl = row * (nx + 1) + col;
        bl = (row + 1) * (nx + 1) + col;
        e.idx_tl = 21'(tl);
        e.idx_tr = 21'(tl + 1);
        e.idx_bl = 21'(bl);
        e.idx_br = 21'(bl + 1);
        e.quad_valid = (col < nx && row < ny);
      end
      pending = {pending, e};
    endfunction

    function void check_vertex(vertex_t a);
      vertex_t e;
      if (pending.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (a.pos_x !== e.pos_x) begin
        $error("pos_x exp %0d got %0d", e.pos_x, a.pos_x); errors++;
      end
      if (a.pos_y !== e.pos_y) begin
        $error("pos_y exp %0d got %0d", e.pos_y, a.pos_y); errors++;
      end
      if (a.pos_z !== e.pos_z) begin
        $error("pos_z exp %0d got %0d", e.pos_z, a.pos_z); errors++;
      end
      if (a.tex_u !== e.tex_u) begin
        $error("tex_u exp %0d got %0d", e.tex_u, a.tex_u); errors++;
      end
      if (a.tex_v !== e.tex_v) begin
        $error("tex_v exp %0d got %0d", e.tex_v, a.tex_v); errors++;
      end
      if (a.idx_tl !== e.idx_tl) begin
        $error("idx_top_left exp %0d got %0d", e.idx_tl, a.idx_tl); errors++;
      end
      if (a.idx_tr !== e.idx_tr) begin
        $error("idx_top_right exp %0d got %0d", e.idx_tr, a.idx_tr); errors++;
      end
      if (a.idx_bl !== e.idx_bl) begin
        $error("idx_bottom_left exp %0d got %0d", e.idx_bl, a.idx_bl); errors++;
      end
      if (a.idx_br !== e.idx_br) begin
        $error("idx_bottom_right exp %0d got %0d", e.idx_br, a.idx_br); errors++;
      end
      if (a.quad_valid !== e.quad_valid) begin
        $error("quad_valid exp %0d got %0d", e.quad_valid, a.quad_valid); errors++;
      end
      if (a.out_of_range !== e.out_of_range) begin
        $error("out_of_range exp %0d got %0d", e.out_of_range, a.out_of_range); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int idle_cycles = 0;
  int sent = 0;
  bit rsp_stall_en = 1;

  uvs_req_if req ();
  uvs_rsp_if rsp ();

  uv_sphere_vertex_generator DUT (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  vertex_scoreboard sb = new();

  always #4 clk = ~clk;

  initial begin
    req.valid = 0;
    req.column = '0;
    req.row = '0;
    rsp.ready = 0;
  end

  function int gap_len();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: optional random backpressure, checks on every accepted transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp.valid && rsp.ready)
        sb.check_vertex({rsp.pos_x, rsp.pos_y, rsp.pos_z, rsp.tex_u, rsp.tex_v,
                         rsp.idx_top_left, rsp.idx_top_right, rsp.idx_bottom_left,
                         rsp.idx_bottom_right, rsp.quad_valid, rsp.out_of_range});
      rsp.ready <= rsp_stall_en ? (gap_len() == 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_idx_t r, logic [31:0] val);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= 3'(4 * int'(r)); pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    if (r == REG_X_SEGMENTS) sb.xseg = val[10:0];
    else sb.yseg = val[10:0];
  endtask

  task automatic send_point(logic [10:0] c, logic [10:0] r);
    int g;
    g = gap_len();
    if (g > 0) begin
      req.valid <= 0;
      repeat (g) @(posedge clk);
    end
    req.valid <= 1; req.column <= c; req.row <= r;
    do @(posedge clk); while (!req.ready);
    sb.note_point(c, r);
    sent++;
  endtask

  // valid drops at the edge that took the last transaction
  task automatic drain();
    req.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    logic [10:0] c, r;
    int nx, ny;
    nx = int'(sb.seg_limit(sb.xseg));
    ny = int'(sb.seg_limit(sb.yseg));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8) begin
        c = 11'($urandom_range(0, nx));
        r = 11'($urandom_range(0, ny));
      end else begin
        c = 11'($urandom);
        r = 11'($urandom);
      end
      send_point(c, r);
    end
  endtask

  initial begin
    logic [10:0] segs [8];
    segs = '{11'd0, 11'd1, 11'd2, 11'd3, 11'd1024, 11'd1025, 11'd2047, 11'd36};
    repeat (2) @(posedge clk);
    rst <= 0;
    // directed: reset geometry, poles, seam, grid edge, out of range
    send_point(11'd0, 11'd0);
    send_point(11'd36, 11'd0);
    send_point(11'd0, 11'd18);
    send_point(11'd9, 11'd9);
    send_point(11'd18, 11'd9);
    send_point(11'd27, 11'd4);
    send_point(11'd35, 11'd17);
    send_point(11'd36, 11'd18);
    send_point(11'd37, 11'd0);
    send_point(11'd0, 11'd19);
    send_point(11'h7FF, 11'h7FF);
    send_point(11'h400, 11'h400);
    drain();
    write_reg(REG_X_SEGMENTS, 32'd0);
    write_reg(REG_Y_SEGMENTS, 32'hFFFF_FFFF);
    send_point(11'd0, 11'd0);
    send_point(11'd1, 11'd1024);
    send_point(11'd2, 11'd0);
    send_point(11'd1, 11'd512);
    drain();
    write_reg(REG_X_SEGMENTS, 32'd1024);
    write_reg(REG_Y_SEGMENTS, 32'd1);
    send_point(11'd1024, 11'd1);
    send_point(11'd512, 11'd0);
    send_point(11'd1025, 11'd1);
    send_point(11'd256, 11'd2);
    drain();
    for (int p = 0; p < 16; p++) begin
      write_reg(REG_X_SEGMENTS, p < 8 ? segs[p] : $urandom_range(1, 1024));
      write_reg(REG_Y_SEGMENTS, p < 8 ? segs[7 - p] : $urandom_range(1, 1024));
      rsp_stall_en = (p % 4 != 3);
      random_phase(80);
      drain();
    end
    $display("Sent %0d grid points, checked %0d vertex results over 19 segment settings",
             sent, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
